/* src/msp_pkg.sv */
// shared types and constants for the memory section page mapper
// holds item structs, section descriptor layout and the sequencer state type
// no dependencies
package msp_pkg;

    localparam int unsigned SECTIONS   = 4;
    localparam int unsigned SECT_W     = 2;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 44;
    localparam int unsigned QDEPTH     = 2;

    localparam logic [SECT_W-1:0] SECT_LAST      = SECT_W'(SECTIONS - 1);
    localparam logic [17:0]       NOT_FOUND_PAGE = 18'h3FFFF;
    localparam logic [4:0]        DIV_LAST       = 5'd31;

    // command codes on the input channel
    localparam logic [1:0] CMD_ADDR_TO_PAGE = 2'd0;
    localparam logic [1:0] CMD_PAGE_TO_ADDR = 2'd1;
    localparam logic [1:0] CMD_TOTALS       = 2'd2;

    // register index bit 0 selects base or descriptor
    localparam logic REG_KIND_DESC = 1'b1;

    // flag bit that puts a section in the flash numbering
    localparam int unsigned FLAG_FLASH = 0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
        logic [31:0] access_length;
        logic [17:0] page_index;
        logic [3:0]  type_mask;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [17:0] page_number;
        logic [3:0]  section_flags;
        logic [31:0] page_address;
        logic [23:0] page_bytes;
        logic [17:0] total_pages;
        logic [41:0] total_bytes;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_A2P,
        OP_P2A,
        OP_TOT,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] address;
        logic [32:0] acc_end;
        logic [17:0] page_index;
        logic [3:0]  type_mask;
    } job_t;

    typedef struct packed {
        logic [31:0] base;
        logic [23:0] psize;
        logic [15:0] pcount;
        logic [3:0]  flags;
    } sect_t;

    typedef sect_t [SECTIONS-1:0] sect_arr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_AMUL,
        ST_ADD,
        ST_OUT
    } st_t;

endpackage

/* src/msp_front.sv */
// front end: takes input items, decodes the command, forms the range end
// and holds decoded jobs in a two-entry queue for the back end; uses msp_pkg
module msp_front import msp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job_data
);

    job_t        q_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    job_t        dec;

    always_comb begin
        dec.address    = s_data.address;
        dec.acc_end    = {1'b0, s_data.address} + {1'b0, s_data.access_length};
        dec.page_index = s_data.page_index;
        dec.type_mask  = s_data.type_mask;
        case (s_data.cmd)
            CMD_ADDR_TO_PAGE: dec.op = OP_A2P;
            CMD_PAGE_TO_ADDR: dec.op = OP_P2A;
            CMD_TOTALS:       dec.op = OP_TOT;
            default:          dec.op = OP_BAD;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'(QDEPTH));
    assign job_valid = (cnt_reg != 2'd0);
    assign job_data  = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

/* src/msp_back.sv */
// back end: walks the sections (multiply, then compare), runs a restoring
// divide for the page offset and drives the result register; uses msp_pkg
module msp_back import msp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sect_arr_t sect_i,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    st_t              state_reg, state_next;
    job_t             job_reg, job_next;
    logic [SECT_W-1:0] idx_reg, idx_next;
    logic [17:0]      flash_run_reg, flash_run_next;
    logic [17:0]      other_run_reg, other_run_next;
    logic [17:0]      run_reg, run_next;
    logic [17:0]      tp_reg, tp_next;
    logic [41:0]      tb_reg, tb_next;
    logic [39:0]      prod_reg, prod_next;
    logic [31:0]      off_reg, off_next;
    logic [24:0]      rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;
    out_item_t        res_reg, res_next;
    out_item_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    sect_t            cur;
    logic             out_load;
    logic [31:0]      mul_a;
    logic [55:0]      mul_full;
    logic [40:0]      sect_end;
    logic             a2p_hit;
    logic             sect_match;
    logic [18:0]      run_sum;
    logic             p2a_hit;
    logic             is_flash;
    logic [24:0]      rem_sh;
    logic [24:0]      rem_sub;
    logic             div_ge;
    out_item_t        not_found;

    assign cur        = sect_i[idx_reg];
    assign mul_a      = (state_reg == ST_MUL) ? {16'd0, cur.pcount} : off_reg;
    assign mul_full   = {24'd0, mul_a} * {32'd0, cur.psize};
    assign sect_end   = {9'd0, cur.base} + {1'b0, prod_reg};
    assign a2p_hit    = (job_reg.address >= cur.base) && ({8'd0, job_reg.acc_end} <= sect_end);
    assign sect_match = |(cur.flags & job_reg.type_mask);
    assign run_sum    = {1'b0, run_reg} + {3'd0, cur.pcount};
    assign p2a_hit    = ({1'b0, job_reg.page_index} < run_sum);
    assign is_flash   = cur.flags[FLAG_FLASH];
    assign rem_sh     = {rem_reg[23:0], off_reg[31]};
    assign rem_sub    = rem_sh - {1'b0, cur.psize};
    assign div_ge     = (rem_sh >= {1'b0, cur.psize});

    always_comb begin
        not_found             = '0;
        not_found.status      = 1'b1;
        not_found.page_number = NOT_FOUND_PAGE;
    end

    // control outputs
    always_comb begin
        job_ready = (state_reg == ST_IDLE);
        out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = (job_data.op == OP_BAD) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: state_next = ST_CHK;
            ST_CHK: begin
                case (job_reg.op)
                    OP_A2P: begin
                        if (a2p_hit) begin
                            state_next = (cur.psize == 24'd0) ? ST_AMUL : ST_DIV;
                        end else begin
                            state_next = (idx_reg == SECT_LAST) ? ST_OUT : ST_MUL;
                        end
                    end
                    OP_P2A: begin
                        if (sect_match && p2a_hit) begin
                            state_next = ST_AMUL;
                        end else begin
                            state_next = (idx_reg == SECT_LAST) ? ST_OUT : ST_MUL;
                        end
                    end
                    default: state_next = (idx_reg == SECT_LAST) ? ST_OUT : ST_MUL;
                endcase
            end
            ST_DIV:  state_next = (cnt_reg == DIV_LAST) ? ST_AMUL : ST_DIV;
            ST_AMUL: state_next = ST_ADD;
            ST_ADD:  state_next = ST_OUT;
            ST_OUT:  state_next = out_load ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        job_next       = job_reg;
        idx_next       = idx_reg;
        flash_run_next = flash_run_reg;
        other_run_next = other_run_reg;
        run_next       = run_reg;
        tp_next        = tp_reg;
        tb_next        = tb_reg;
        prod_next      = prod_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_next       = job_data;
                    idx_next       = '0;
                    flash_run_next = '0;
                    other_run_next = '0;
                    run_next       = '0;
                    tp_next        = '0;
                    tb_next        = '0;
                    res_next        = '0;
                    res_next.status = 1'b1;
                end
            end
            ST_MUL: prod_next = mul_full[39:0];
            ST_CHK: begin
                case (job_reg.op)
                    OP_A2P: begin
                        if (a2p_hit) begin
                            run_next = is_flash ? flash_run_reg : other_run_reg;
                            off_next = (cur.psize == 24'd0) ? 32'd0 : job_reg.address - cur.base;
                            rem_next = '0;
                            cnt_next = '0;
                        end else begin
                            if (is_flash) begin
                                flash_run_next = flash_run_reg + {2'd0, cur.pcount};
                            end else begin
                                other_run_next = other_run_reg + {2'd0, cur.pcount};
                            end
                            idx_next = idx_reg + SECT_W'(1);
                            res_next = not_found;
                        end
                    end
                    OP_P2A: begin
                        if (sect_match && p2a_hit) begin
                            off_next = {14'd0, job_reg.page_index - run_reg};
                        end else begin
                            if (sect_match) begin
                                run_next = run_sum[17:0];
                            end
                            idx_next = idx_reg + SECT_W'(1);
                            res_next = not_found;
                        end
                    end
                    default: begin
                        if (sect_match) begin
                            tp_next = tp_reg + {2'd0, cur.pcount};
                            tb_next = tb_reg + {2'd0, prod_reg};
                        end
                        idx_next             = idx_reg + SECT_W'(1);
                        res_next             = '0;
                        res_next.total_pages = tp_next;
                        res_next.total_bytes = tb_next;
                    end
                endcase
            end
            ST_DIV: begin
                // one quotient bit per cycle, dividend shifts out of off_reg
                rem_next = div_ge ? rem_sub : rem_sh;
                off_next = {off_reg[30:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
            end
            ST_AMUL: prod_next = mul_full[39:0];
            ST_ADD: begin
                res_next               = '0;
                res_next.status        = 1'b0;
                res_next.page_number   = (job_reg.op == OP_A2P) ? run_reg + off_reg[17:0]
                                                                : job_reg.page_index;
                res_next.section_flags = cur.flags;
                res_next.page_address  = cur.base + prod_reg[31:0];
                res_next.page_bytes    = cur.psize;
            end
            ST_OUT: begin
                if (out_load) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg       <= job_next;
        idx_reg       <= idx_next;
        flash_run_reg <= flash_run_next;
        other_run_reg <= other_run_next;
        run_reg       <= run_next;
        tp_reg        <= tp_next;
        tb_reg        <= tb_next;
        prod_reg      <= prod_next;
        off_reg       <= off_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* src/memory_section_page_mapper.sv */
// memory section page mapper top level: section registers, front end, back end
// depends on msp_pkg, msp_front and msp_back
//
// usage:
//   s_valid/s_ready/s_data carry command items (address to page, page to
//   address, mask totals); m_valid/m_ready/m_data carry one result item each.
//   cfg_we/cfg_index/cfg_data write the base or the descriptor of one
//   of four sections, with no read-back; write only while the block is idle.
// sequence:
//   an item is registered in the front queue, then the back sequencer
//   visits the sections, each with a multiply state, then a compare state.
//   address to page on a hit adds a restoring divide for the page offset
//   (skipped for a zero page size), then the page address multiply and
//   add; page to address adds the multiply and add only. a last state
//   loads the result register. items are worked one at a time; the
//   two-entry queue keeps taking items while the back end is busy.
// reset:
//   aresetn (synchronous, active low) clears all section registers, empties
//   the queue and drops m_valid. a stalled m_ready holds the result register
//   and the back end waits with its next result, the queue fills, then
//   s_ready drops.
module memory_section_page_mapper import msp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [31:0]           base_reg [SECTIONS];
    logic [43:0]           desc_reg [SECTIONS];
    sect_arr_t             sect;
    logic [SECT_W-1:0]     cfg_sect;
    logic                  job_valid;
    logic                  job_ready;
    job_t                  job_data;

    assign cfg_sect = cfg_index[REG_IDX_W-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SECTIONS; i++) begin
                base_reg[i] <= '0;
                desc_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index[0] == REG_KIND_DESC) begin
                desc_reg[cfg_sect] <= cfg_data;
            end else begin
                base_reg[cfg_sect] <= cfg_data[31:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SECTIONS; i++) begin
            sect[i].base   = base_reg[i];
            sect[i].psize  = desc_reg[i][23:0];
            sect[i].pcount = desc_reg[i][39:24];
            sect[i].flags  = desc_reg[i][43:40];
        end
    end

    msp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data)
    );

    msp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sect_i    (sect),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
